[hdl/countdown_segment_display_driver_top_macros.svh]
// Assertion macros used by the countdown display driver controller.
`ifndef COUNTDOWN_SEGMENT_DISPLAY_DRIVER_TOP_MACROS_SVH
`define COUNTDOWN_SEGMENT_DISPLAY_DRIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CDSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CDSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cdsd_pkg.sv]
// Shared types and constants of the countdown display driver.
`default_nettype none

package cdsd_pkg;

  // Width of the tick counters; they saturate at their all-ones value.
  localparam int COUNT_WIDTH = 16;
  // Compare width that covers both a counter and a 16-bit period.
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int PERIOD_W = 16;

  // Serial divider geometry.
  localparam int DIV_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Configuration port geometry.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Show-time limits.
  localparam logic [14:0] SECS_MAX = 15'd5999;
  localparam logic [15:0] SECS_PER_MIN = 16'd60;
  // Minutes = (seconds * SECS_RECIP) >> 19, exact for seconds up to 5999.
  localparam logic [13:0] SECS_RECIP = 14'd8739;

  // Segment bytes.
  localparam logic [7:0] SEG_G = 8'h40;
  localparam logic [7:0] COLON_BIT = 8'h80;
  localparam logic [7:0] SEG_LO_B = 8'h7C;
  localparam logic [7:0] SEG_LO_O = 8'h5C;
  localparam logic [7:0] SEG_LO_N = 8'h54;
  localparam logic [7:0] SEG_S = 8'h6D;
  localparam logic [7:0] SEG_A = 8'h77;
  localparam logic [7:0] SEG_F = 8'h71;
  localparam logic [7:0] SEG_E = 8'h79;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_SHOW  = 3'd1,
    OP_BOOM  = 3'd2,
    OP_BLINK = 3'd3,
    OP_DASH  = 3'd4,
    OP_SAFE  = 3'd5,
    OP_SET   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BOOM  = 2'd1,
    KIND_BLINK = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_COLON_EN     = 3'd0,
    REG_BLANK_EN     = 3'd1,
    REG_BLANK_MIN    = 3'd2,
    REG_COLON_PERIOD = 3'd3,
    REG_BLANK_PERIOD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                colon_en;
    logic                blank_en;
    logic                blank_min;
    logic [PERIOD_W-1:0] colon_period;
    logic [PERIOD_W-1:0] blank_period;
  } cdsd_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic commit;
    logic out_load;
  } cdsd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_div;
    logic div_busy;
    logic emit_req;
  } cdsd_sts_t;

endpackage

`default_nettype wire

[hdl/cdsd_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module cdsd_regs import cdsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cdsd_cfg_t              cfg
);

  cdsd_cfg_t cfg_r, cfg_nxt;
  logic      wr_en;
  reg_idx_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  // Decode the write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_COLON_EN:     cfg_nxt.colon_en     = pwdata[0];
        REG_BLANK_EN:     cfg_nxt.blank_en     = pwdata[0];
        REG_BLANK_MIN:    cfg_nxt.blank_min    = pwdata[0];
        REG_COLON_PERIOD: cfg_nxt.colon_period = pwdata[PERIOD_W-1:0];
        REG_BLANK_PERIOD: cfg_nxt.blank_period = pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_COLON_EN:     prdata = APB_DW'(cfg_r.colon_en);
      REG_BLANK_EN:     prdata = APB_DW'(cfg_r.blank_en);
      REG_BLANK_MIN:    prdata = APB_DW'(cfg_r.blank_min);
      REG_COLON_PERIOD: prdata = APB_DW'(cfg_r.colon_period);
      REG_BLANK_PERIOD: prdata = APB_DW'(cfg_r.blank_period);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colon_en     <= 1'b0;
      cfg_r.blank_en     <= 1'b1;
      cfg_r.blank_min    <= 1'b0;
      cfg_r.colon_period <= PERIOD_W'(500);
      cfg_r.blank_period <= PERIOD_W'(500);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/cdsd_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module cdsd_div import cdsd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic      [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIV_W:0]       rem_shift;
  logic [DIV_W:0]       diff;

  assign rem_shift = {rem_r, quo_r[DIV_W-1]};
  assign diff      = rem_shift - {1'b0, dsr_r};

  // Load operands or shift in one quotient bit
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hdl/cdsd_dpath.sv]
// Datapath: phase and animation state, divider, segment result register.
`default_nettype none

module cdsd_dpath import cdsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [14:0] in_seconds_left,
  input  wire logic [15:0] in_anim_period,
  input  wire logic [15:0] in_anim_length,
  input  wire logic        in_anim_repeat,
  input  wire logic        in_colon_value,
  input  wire logic        in_blank_value,
  input  cdsd_cfg_t        cfg,
  input  cdsd_cmd_t        cmd,
  output cdsd_sts_t        sts,
  output logic [7:0]       out_digit0_segs,
  output logic [7:0]       out_digit1_segs,
  output logic [7:0]       out_digit2_segs,
  output logic [7:0]       out_digit3_segs,
  output logic             out_anim_busy
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Tens of a value below 100 by reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] r;
    r = v - 7'(t) * 7'd10;
    return r[3:0];
  endfunction

  // Latched transaction
  op_t               op_r;
  logic [15:0]       period_r;
  logic              repeat_r;
  logic              colon_val_r;
  logic              blank_val_r;
  logic [6:0]        mm_r;
  logic [5:0]        ss_r;

  // Display state
  logic                   colon_phase_r, colon_phase_nxt;
  logic                   blank_phase_r, blank_phase_nxt;
  logic [COUNT_WIDTH-1:0] colon_cnt_r, colon_cnt_nxt;
  logic [COUNT_WIDTH-1:0] blank_cnt_r, blank_cnt_nxt;
  logic [COUNT_WIDTH-1:0] anim_cnt_r, anim_cnt_nxt;
  logic [15:0]            step_period_r, step_period_nxt;
  logic [15:0]            iter_r, iter_nxt;
  kind_t                  kind_r, kind_nxt;
  logic                   shown_r, shown_nxt;
  logic                   forever_r, forever_nxt;

  // Result register
  logic [7:0] d0_r, d1_r, d2_r, d3_r;
  logic       busy_r;
  logic [7:0] d0_nxt, d1_nxt, d2_nxt, d3_nxt;

  // Divider hookup
  op_t         in_op;
  logic [15:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_busy;
  logic [15:0] div_quo;

  // Status terms
  logic        needs_div;
  logic        emit_req;

  // Minutes and seconds of the incoming transaction
  logic [12:0] secs_sat;
  logic [26:0] mm_prod;
  logic [6:0]  mm_calc;
  logic [12:0] ss_full;

  // Tick terms
  logic [COUNT_WIDTH-1:0] colon_inc, blank_inc, anim_inc;
  logic                   colon_hit, blank_hit, anim_hit;
  logic [15:0]            iter_dec, iter_tick;

  // Time digits
  logic [6:0] mm, ss;
  logic [3:0] mm_t, mm_o, ss_t, ss_o;

  assign in_op = op_t'(in_opcode);

  // Divide the animation length by its period, zero period counting as one
  assign div_dividend = in_anim_length;
  assign div_divisor  = (in_anim_period == 16'd0) ? 16'd1 : in_anim_period;

  cdsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo)
  );

  // Split saturated seconds into minutes and seconds by reciprocal multiply
  assign secs_sat = (in_seconds_left > SECS_MAX) ? 13'(SECS_MAX) : in_seconds_left[12:0];
  assign mm_prod  = 27'(secs_sat) * 27'(SECS_RECIP);
  assign mm_calc  = mm_prod[25:19];
  assign ss_full  = secs_sat - 13'(mm_calc) * 13'(SECS_PER_MIN);

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r        <= in_op;
      period_r    <= in_anim_period;
      repeat_r    <= in_anim_repeat;
      colon_val_r <= in_colon_value;
      blank_val_r <= in_blank_value;
      mm_r        <= mm_calc;
      ss_r        <= ss_full[5:0];
    end
  end

  // Saturating counters and toggle detection
  always_comb begin
    colon_inc = (colon_cnt_r == CNT_MAX) ? colon_cnt_r : colon_cnt_r + 1'b1;
    blank_inc = (blank_cnt_r == CNT_MAX) ? blank_cnt_r : blank_cnt_r + 1'b1;
    anim_inc  = (anim_cnt_r == CNT_MAX) ? anim_cnt_r : anim_cnt_r + 1'b1;
    colon_hit = cfg.colon_en && (CMP_W'(colon_inc) > CMP_W'(cfg.colon_period));
    blank_hit = cfg.blank_en && (CMP_W'(blank_inc) > CMP_W'(cfg.blank_period));
    anim_hit  = (kind_r != KIND_NONE) && (CMP_W'(anim_inc) > CMP_W'(step_period_r));
    iter_dec  = (iter_r != 16'd0) ? iter_r - 16'd1 : 16'd0;
    iter_tick = ((iter_dec == 16'd0) && forever_r) ? 16'd1 : iter_dec;
  end

  // Next state of the display
  always_comb begin
    colon_phase_nxt = colon_phase_r;
    blank_phase_nxt = blank_phase_r;
    colon_cnt_nxt   = colon_cnt_r;
    blank_cnt_nxt   = blank_cnt_r;
    anim_cnt_nxt    = anim_cnt_r;
    step_period_nxt = step_period_r;
    iter_nxt        = iter_r;
    kind_nxt        = kind_r;
    shown_nxt       = shown_r;
    forever_nxt     = forever_r;
    case (op_r)
      OP_TICK: begin
        colon_cnt_nxt = colon_hit ? '0 : colon_inc;
        colon_phase_nxt = colon_phase_r ^ colon_hit;
        blank_cnt_nxt = blank_hit ? '0 : blank_inc;
        blank_phase_nxt = blank_phase_r ^ blank_hit;
        if (kind_r != KIND_NONE) begin
          anim_cnt_nxt = anim_hit ? '0 : anim_inc;
          if (anim_hit) begin
            shown_nxt = ~shown_r;
            iter_nxt  = iter_tick;
            if (iter_tick == 16'd0) begin
              kind_nxt    = KIND_NONE;
              forever_nxt = 1'b0;
            end
          end
        end
      end
      OP_BOOM, OP_BLINK: begin
        kind_nxt        = (op_r == OP_BOOM) ? KIND_BOOM : KIND_BLINK;
        shown_nxt       = 1'b1;
        iter_nxt        = div_quo;
        step_period_nxt = period_r;
        forever_nxt     = (op_r == OP_BLINK) && repeat_r;
        anim_cnt_nxt    = '0;
      end
      OP_SET: begin
        colon_phase_nxt = colon_val_r;
        blank_phase_nxt = blank_val_r;
      end
      default: ;
    endcase
  end

  // Split minutes and seconds into decimal digits
  assign mm   = mm_r;
  assign ss   = {1'b0, ss_r};
  assign mm_t = tens_of(mm);
  assign mm_o = ones_of(mm, mm_t);
  assign ss_t = tens_of(ss);
  assign ss_o = ones_of(ss, ss_t);

  // Result segments
  always_comb begin
    d0_nxt   = SEG_BLANK;
    d1_nxt   = SEG_BLANK;
    d2_nxt   = SEG_BLANK;
    d3_nxt   = SEG_BLANK;
    emit_req = 1'b0;
    case (op_r)
      OP_TICK: begin
        emit_req = anim_hit && (kind_r == KIND_BOOM);
        if (shown_nxt) begin
          d0_nxt = SEG_LO_B;
          d1_nxt = SEG_LO_O;
          d2_nxt = SEG_LO_O;
          d3_nxt = SEG_LO_N;
        end
      end
      OP_SHOW: begin
        emit_req = 1'b1;
        d0_nxt = seg_of(mm_t);
        d1_nxt = seg_of(mm_o);
        d2_nxt = seg_of(ss_t);
        d3_nxt = seg_of(ss_o);
        if (blank_phase_r) begin
          if (cfg.blank_min) begin
            d0_nxt = SEG_BLANK;
            d1_nxt = SEG_BLANK;
          end else begin
            d2_nxt = SEG_BLANK;
            d3_nxt = SEG_BLANK;
          end
        end
        if (colon_phase_r) begin
          d1_nxt = d1_nxt | COLON_BIT;
        end
      end
      OP_DASH: begin
        emit_req = 1'b1;
        d0_nxt = SEG_G;
        d1_nxt = SEG_G;
        d2_nxt = SEG_G;
        d3_nxt = SEG_G;
      end
      OP_SAFE: begin
        emit_req = 1'b1;
        d0_nxt = SEG_S;
        d1_nxt = SEG_A;
        d2_nxt = SEG_F;
        d3_nxt = SEG_E;
      end
      default: ;
    endcase
  end

  assign needs_div = (in_op == OP_BOOM) || (in_op == OP_BLINK);
  assign sts       = '{needs_div: needs_div, div_busy: div_busy, emit_req: emit_req};

  // Commit state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_phase_r <= 1'b0;
      blank_phase_r <= 1'b1;
      colon_cnt_r   <= '0;
      blank_cnt_r   <= '0;
      anim_cnt_r    <= '0;
      step_period_r <= 16'd100;
      iter_r        <= 16'd0;
      kind_r        <= KIND_NONE;
      shown_r       <= 1'b1;
      forever_r     <= 1'b0;
    end else if (cmd.commit) begin
      colon_phase_r <= colon_phase_nxt;
      blank_phase_r <= blank_phase_nxt;
      colon_cnt_r   <= colon_cnt_nxt;
      blank_cnt_r   <= blank_cnt_nxt;
      anim_cnt_r    <= anim_cnt_nxt;
      step_period_r <= step_period_nxt;
      iter_r        <= iter_nxt;
      kind_r        <= kind_nxt;
      shown_r       <= shown_nxt;
      forever_r     <= forever_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
      busy_r <= (kind_nxt != KIND_NONE);
    end
  end

  assign out_digit0_segs = d0_r;
  assign out_digit1_segs = d1_r;
  assign out_digit2_segs = d2_r;
  assign out_digit3_segs = d3_r;
  assign out_anim_busy   = busy_r;

endmodule

`default_nettype wire

[hdl/cdsd_ctrl.sv]
// Controller: sequences accept, divide and commit, and owns the result valid.
`default_nettype none

`include "countdown_segment_display_driver_top_macros.svh"

module cdsd_ctrl import cdsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cdsd_cmd_t cmd,
  input  cdsd_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_APPLY  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.div_start = sts.needs_div;
          state_nxt     = sts.needs_div ? ST_DIVIDE : ST_APPLY;
        end
      end
      ST_DIVIDE: begin
        if (!sts.div_busy) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold while a result is due and the output slot is full
        if (!sts.emit_req || slot_free) begin
          cmd.commit   = 1'b1;
          cmd.out_load = sts.emit_req;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Track the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CDSD_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, in_ready, !sts.div_busy, "divider busy while idle")
  `CDSD_ASSERT_IMP(a_load_slot_free, clk, rst_n, cmd.out_load, slot_free, "result overwrites pending transaction")
  `CDSD_ASSERT_NXT(a_start_divides, clk, rst_n, cmd.div_start, (state_r == ST_DIVIDE) && sts.div_busy, "divide not started")

endmodule

`default_nettype wire

[hdl/countdown_segment_display_driver_top.sv]
// Countdown display driver: four-digit seven-segment result per transaction.
//
// Input channel (in_valid/in_ready) carries one opcode item: tick, show time,
// start boom, start blink, dashes, safe or set phases. Result channel
// (out_valid/out_ready) carries four segment bytes and the animation busy flag.
// Show time, dashes and safe always give a result; a tick gives one only when
// the boom animation toggles; the other opcodes give none.
// One transaction is worked on at a time. Tick, show time, dashes, safe and set
// phases pass from accept through an apply state, which commits the display
// state and loads any result register; show time splits minutes and seconds by
// a reciprocal multiply as it is accepted. Start boom and start blink first run
// the 16-step serial divider (length by period) in a divide state before apply.
// The result sits in an output register: the next transaction is accepted while
// it waits. If a stalled receiver still holds the previous result when a new
// one is due, the block holds that transaction until the register frees.
// Reset (synchronous, active low) restores configuration, sequencer and display
// state to their defaults and drops out_valid; the user writes configuration
// over the APB-style port only while idle, which the block does not enforce.
`default_nettype none

module countdown_segment_display_driver_top import cdsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [14:0]       in_seconds_left,
  input  wire logic [15:0]       in_anim_period,
  input  wire logic [15:0]       in_anim_length,
  input  wire logic              in_anim_repeat,
  input  wire logic              in_colon_value,
  input  wire logic              in_blank_value,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_digit0_segs,
  output logic      [7:0]        out_digit1_segs,
  output logic      [7:0]        out_digit2_segs,
  output logic      [7:0]        out_digit3_segs,
  output logic                   out_anim_busy
);

  cdsd_cfg_t cfg;
  cdsd_cmd_t cmd;
  cdsd_sts_t sts;

  cdsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cdsd_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_seconds_left (in_seconds_left),
    .in_anim_period  (in_anim_period),
    .in_anim_length  (in_anim_length),
    .in_anim_repeat  (in_anim_repeat),
    .in_colon_value  (in_colon_value),
    .in_blank_value  (in_blank_value),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .out_digit0_segs (out_digit0_segs),
    .out_digit1_segs (out_digit1_segs),
    .out_digit2_segs (out_digit2_segs),
    .out_digit3_segs (out_digit3_segs),
    .out_anim_busy   (out_anim_busy)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the countdown seven-segment display driver.
`timescale 1ns / 100ps

module tb;
  import cdsd_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int PHASE_ITEMS = 250;
  localparam int QUIET_TICKS = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  // Segment patterns of the digits 9 down to 0.
  localparam logic [9:0][7:0] DIGIT_FONT = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                            8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef struct packed {
    logic [2:0]  opcode;
    logic [14:0] secs;
    logic [15:0] period;
    logic [15:0] length;
    logic        endless;
    logic        colon_val;
    logic        blank_val;
  } item_t;

  typedef struct packed {
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] digit3;
    logic       busy;
  } display_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [14:0] in_seconds_left = '0;
  logic [15:0] in_anim_period = '0;
  logic [15:0] in_anim_length = '0;
  logic in_anim_repeat = 1'b0;
  logic in_colon_value = 1'b0;
  logic in_blank_value = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_digit0_segs;
  logic [7:0] out_digit1_segs;
  logic [7:0] out_digit2_segs;
  logic [7:0] out_digit3_segs;
  logic out_anim_busy;

  // Stimulus and expectation stores.
  item_t pending_items[$];
  display_t display_expected[$];
  item_t next_item;

  // Mirror of the display state and settings.
  logic colon_blink_on, blank_blink_on, blank_minute_pair;
  logic [15:0] colon_limit, blank_limit;
  logic colon_on, blank_on, anim_visible, anim_endless;
  logic [COUNT_WIDTH-1:0] colon_ticks, blank_ticks, anim_ticks;
  logic [15:0] anim_toggle_period, toggles_left;
  kind_t anim_mode;

  // Bookkeeping.
  int error_count = 0;
  int items_accepted = 0;
  int ticks_accepted = 0;
  int results_checked = 0;
  int boom_frames = 0;
  int settings_applied = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_off_req = 1'b0;
  logic ready_next;
  logic [15:0] rx_cycle = '0;

  countdown_segment_display_driver_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seconds_left (in_seconds_left),
    .in_anim_period  (in_anim_period),
    .in_anim_length  (in_anim_length),
    .in_anim_repeat  (in_anim_repeat),
    .in_colon_value  (in_colon_value),
    .in_blank_value  (in_blank_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit0_segs (out_digit0_segs),
    .out_digit1_segs (out_digit1_segs),
    .out_digit2_segs (out_digit2_segs),
    .out_digit3_segs (out_digit3_segs),
    .out_anim_busy   (out_anim_busy)
  );

  // Generate the 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the display mirror by one transaction and queue the frame it shows.
  function automatic void predict_display(input item_t it);
    display_t frame;
    logic has_frame;
    logic was_boom;
    int secs, mins, rem, divisor;
    has_frame = 1'b0;
    frame = '0;
    case (it.opcode)
      OP_TICK: begin
        if (colon_ticks != '1) colon_ticks = colon_ticks + 1'b1;
        if (colon_blink_on && colon_ticks > colon_limit) begin
          colon_ticks = '0;
          colon_on = ~colon_on;
        end
        if (blank_ticks != '1) blank_ticks = blank_ticks + 1'b1;
        if (blank_blink_on && blank_ticks > blank_limit) begin
          blank_ticks = '0;
          blank_on = ~blank_on;
        end
        if (anim_mode != KIND_NONE) begin
          if (anim_ticks != '1) anim_ticks = anim_ticks + 1'b1;
          if (anim_ticks > anim_toggle_period) begin
            was_boom = (anim_mode == KIND_BOOM);
            anim_ticks = '0;
            anim_visible = ~anim_visible;
            if (toggles_left != 0) toggles_left = toggles_left - 1'b1;
            if (toggles_left == 0 && anim_endless) toggles_left = 16'd1;
            if (toggles_left == 0) begin
              anim_mode = KIND_NONE;
              anim_endless = 1'b0;
            end
            // Boom frames alternate between the word and a dark display.
            if (was_boom) begin
              has_frame = 1'b1;
              boom_frames++;
              if (anim_visible) begin
                frame.digit0 = SEG_LO_B;
                frame.digit1 = SEG_LO_O;
                frame.digit2 = SEG_LO_O;
                frame.digit3 = SEG_LO_N;
              end
            end
          end
        end
      end
      OP_SHOW: begin
        has_frame = 1'b1;
        secs = (it.secs > SECS_MAX) ? int'(SECS_MAX) : int'(it.secs);
        mins = secs / int'(SECS_PER_MIN);
        rem = secs % int'(SECS_PER_MIN);
        frame.digit0 = DIGIT_FONT[(mins / 10) % 10];
        frame.digit1 = DIGIT_FONT[mins % 10];
        frame.digit2 = DIGIT_FONT[(rem / 10) % 10];
        frame.digit3 = DIGIT_FONT[rem % 10];
        if (blank_on) begin
          if (blank_minute_pair) begin
            frame.digit0 = SEG_BLANK;
            frame.digit1 = SEG_BLANK;
          end else begin
            frame.digit2 = SEG_BLANK;
            frame.digit3 = SEG_BLANK;
          end
        end
        if (colon_on) frame.digit1 = frame.digit1 | COLON_BIT;
      end
      OP_BOOM, OP_BLINK: begin
        divisor = (it.period == 0) ? 1 : int'(it.period);
        anim_mode = (it.opcode == OP_BOOM) ? KIND_BOOM : KIND_BLINK;
        anim_visible = 1'b1;
        toggles_left = 16'(int'(it.length) / divisor);
        anim_toggle_period = it.period;
        anim_endless = (it.opcode == OP_BLINK) && it.endless;
        anim_ticks = '0;
      end
      OP_DASH: begin
        has_frame = 1'b1;
        frame.digit0 = SEG_G;
        frame.digit1 = SEG_G;
        frame.digit2 = SEG_G;
        frame.digit3 = SEG_G;
      end
      OP_SAFE: begin
        has_frame = 1'b1;
        frame.digit0 = SEG_S;
        frame.digit1 = SEG_A;
        frame.digit2 = SEG_F;
        frame.digit3 = SEG_E;
      end
      OP_SET: begin
        colon_on = it.colon_val;
        blank_on = it.blank_val;
      end
      default: ;
    endcase
    if (has_frame) begin
      frame.busy = (anim_mode != KIND_NONE);
      display_expected.push_back(frame);
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      error_count++;
    end
  endfunction

  function automatic item_t make_item(input logic [2:0] op, input int secs, input int period,
                                      input int length, input logic endless,
                                      input logic colon_val, input logic blank_val);
    item_t it;
    it.opcode = op;
    it.secs = 15'(secs);
    it.period = 16'(period);
    it.length = 16'(length);
    it.endless = endless;
    it.colon_val = colon_val;
    it.blank_val = blank_val;
    return it;
  endfunction

  // Mostly ticks and displays, with short animations so that they run out.
  function automatic item_t random_item();
    item_t it;
    int pick;
    it = make_item(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.opcode = OP_TICK;
    end else if (pick < 68) begin
      it.opcode = OP_SHOW;
      case ($urandom_range(0, 3))
        0: it.secs = 15'($urandom_range(0, 5999));
        1: it.secs = 15'($urandom_range(5990, 6010));
        2: it.secs = 15'($urandom_range(0, 119));
        default: ;
      endcase
    end else if (pick < 80) begin
      it.opcode = (pick < 74) ? OP_BOOM : OP_BLINK;
      if ($urandom_range(0, 7) != 0) begin
        it.period = 16'($urandom_range(0, 4));
        it.length = 16'($urandom_range(0, 24));
      end
    end else if (pick < 85) begin
      it.opcode = OP_DASH;
    end else if (pick < 90) begin
      it.opcode = OP_SAFE;
    end else if (pick < 97) begin
      it.opcode = OP_SET;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // Run one register write: setup cycle, then access cycle.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Load every register, with noise in the unused upper bits and a stray address.
  task automatic program_settings(input logic colon_en, input logic blank_en,
                                  input logic blank_min, input logic [15:0] colon_per,
                                  input logic [15:0] blank_per);
    write_register(REG_COLON_EN, {31'($urandom()), colon_en});
    write_register(REG_BLANK_EN, {31'($urandom()), blank_en});
    write_register(REG_BLANK_MIN, {31'($urandom()), blank_min});
    write_register(REG_COLON_PERIOD, {16'($urandom()), colon_per});
    write_register(REG_BLANK_PERIOD, {16'($urandom()), blank_per});
    write_register(3'($urandom_range(5, 7)), $urandom());
    settings_applied++;
  endtask

  // Wait until every transaction is in and every frame is out, then let it settle.
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || display_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive input transactions in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_item.opcode;
        in_seconds_left <= next_item.secs;
        in_anim_period <= next_item.period;
        in_anim_length <= next_item.length;
        in_anim_repeat <= next_item.endless;
        in_colon_value <= next_item.colon_val;
        in_blank_value <= next_item.blank_val;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side: free-running, random and fixed patterns, plus long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      rx_cycle <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (hold_off_req) hold_left <= HOLD_OFF_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      case (rx_cycle[9:8])
        2'd0: ready_next = 1'b1;
        2'd1: ready_next = ($urandom_range(0, 9) < 7);
        2'd2: ready_next = (rx_cycle[2:0] < 3'd5);
        default: ready_next = ($urandom_range(0, 9) < 3);
      endcase
      out_ready <= (hold_off_req || hold_left != 0) ? 1'b0 : ready_next;
    end
  end

  // Track settings, compare frames and predict on every accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      colon_blink_on = 1'b0;
      blank_blink_on = 1'b1;
      blank_minute_pair = 1'b0;
      colon_limit = 16'd500;
      blank_limit = 16'd500;
      colon_on = 1'b0;
      blank_on = 1'b1;
      colon_ticks = '0;
      blank_ticks = '0;
      anim_ticks = '0;
      anim_toggle_period = 16'd100;
      toggles_left = '0;
      anim_mode = KIND_NONE;
      anim_visible = 1'b1;
      anim_endless = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_COLON_EN:     colon_blink_on = pwdata[0];
          REG_BLANK_EN:     blank_blink_on = pwdata[0];
          REG_BLANK_MIN:    blank_minute_pair = pwdata[0];
          REG_COLON_PERIOD: colon_limit = pwdata[15:0];
          REG_BLANK_PERIOD: blank_limit = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (display_expected.size() == 0) begin
          $error("frame with nothing expected: %h %h %h %h busy %b", out_digit0_segs,
                 out_digit1_segs, out_digit2_segs, out_digit3_segs, out_anim_busy);
          error_count++;
        end else begin
          check_field("digit0_segs", display_expected[0].digit0, out_digit0_segs);
          check_field("digit1_segs", display_expected[0].digit1, out_digit1_segs);
          check_field("digit2_segs", display_expected[0].digit2, out_digit2_segs);
          check_field("digit3_segs", display_expected[0].digit3, out_digit3_segs);
          check_field("anim_busy", 8'(display_expected[0].busy), 8'(out_anim_busy));
          void'(display_expected.pop_front());
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_TICK) ticks_accepted++;
        predict_display({in_opcode, in_seconds_left, in_anim_period, in_anim_length,
                         in_anim_repeat, in_colon_value, in_blank_value});
        items_accepted++;
      end
    end
  end

  // Stop the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("countdown_segment_display_driver_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every opcode and the animation corner cases.
    pending_items.push_back(make_item(OP_SHOW, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SHOW, 5999, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SHOW, 32767, 16'hFFFF, 16'hFFFF, 1, 1, 1));
    pending_items.push_back(make_item(OP_DASH, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SAFE, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SET, 0, 0, 0, 0, 1, 0));
    pending_items.push_back(make_item(OP_SHOW, 754, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SET, 0, 0, 0, 0, 1, 1));
    pending_items.push_back(make_item(OP_SHOW, 6000, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_UNUSED, $urandom(), $urandom(), $urandom(), 1, 1, 1));
    // Zero period and zero iterations: one toggle, then done; repeat is ignored.
    pending_items.push_back(make_item(OP_BOOM, 0, 0, 0, 1, 0, 0));
    pending_items.push_back(make_item(OP_SHOW, 61, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_BOOM, 0, 1, 4, 0, 0, 0));
    repeat (6) pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    // Restart mid-animation, then an endless blink.
    pending_items.push_back(make_item(OP_BOOM, 0, 2, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(make_item(OP_BLINK, 0, 0, 2, 1, 0, 0));
    repeat (2) pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SHOW, 3599, 0, 0, 0, 0, 0));
    wait_for_drain();

    // Random phases, each under its own settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_settings(1'b1, 1'b1, 1'b0, 16'd3, 16'd5);
        1: program_settings(1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
        2: program_settings(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
        3: program_settings(1'b1, 1'b0, 1'b0, 16'd7, 16'd2);
        4: program_settings(1'b0, 1'b1, 1'b1, 16'd1, 16'd12);
        default: program_settings(1'b1, 1'b1, 1'b0, 16'd20, 16'd9);
      endcase
      if (phase == 1) begin
        // Hold the result side off while displays keep coming, to back up the input.
        repeat (40) pending_items.push_back(make_item(OP_SHOW, $urandom_range(0, 6500),
                                                      0, 0, 0, 0, 0));
        @(posedge clk);
        hold_off_req <= 1'b1;
        @(posedge clk);
        hold_off_req <= 1'b0;
      end
      if (phase == 3) begin
        // Pause the sender halfway until every frame is back.
        repeat (PHASE_ITEMS / 2) pending_items.push_back(random_item());
        wait_for_drain();
        repeat (PHASE_ITEMS / 2) pending_items.push_back(random_item());
      end else begin
        repeat (PHASE_ITEMS) pending_items.push_back(random_item());
      end
      wait_for_drain();
    end

    // Count with blinking off, then re-enable with short periods so the next tick toggles.
    program_settings(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
    pending_items.push_back(make_item(OP_BOOM, 0, 16'hFFFF, $urandom(), 0, 0, 0));
    repeat (QUIET_TICKS) pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SHOW, 1234, 0, 0, 0, 0, 0));
    wait_for_drain();
    program_settings(1'b1, 1'b1, 1'b0, 16'd3, 16'd5);
    repeat (2) begin
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_SHOW, 2345, 0, 0, 0, 0, 0));
    end
    pending_items.push_back(make_item(OP_BOOM, 0, 0, 3, 0, 0, 0));
    repeat (5) pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SAFE, 0, 0, 0, 0, 0, 0));
    wait_for_drain();

    $display("Drove %0d transactions (%0d ticks) under %0d register settings;",
             items_accepted, ticks_accepted, settings_applied);
    $display("compared %0d display frames (%0d boom frames), %0d field mismatches.",
             results_checked, boom_frames, error_count);
    if (error_count == 0) begin
      $display("countdown_segment_display_driver_top: match");
    end else begin
      $display("countdown_segment_display_driver_top: mismatch");
    end
    $finish;
  end

endmodule
